// ----- rtl/pcx_pkg.sv -----
// Package for the PCX run-length image decoder: request types, phase codes,
// header offsets and the extent helper. Depends on nothing else.
`default_nettype none

package pcx_pkg;

    localparam int unsigned HEADER_BYTES  = 128;
    localparam int unsigned PALETTE_BYTES = 768;

    localparam int unsigned HDR_OFF_W = 7;
    localparam int unsigned COORD_W   = 16;
    localparam int unsigned PAL_W     = 10;
    localparam int unsigned COUNT_W   = 6;

    localparam logic [7:0] RUN_MASK     = 8'hC0;
    localparam logic [7:0] COUNT_MASK   = 8'h3F;
    localparam logic [7:0] PALETTE_MARK = 8'd12;

    // Byte offsets of the window coordinates inside the header
    localparam logic [HDR_OFF_W-1:0] OFF_XMIN_LO = 7'd4;
    localparam logic [HDR_OFF_W-1:0] OFF_XMIN_HI = 7'd5;
    localparam logic [HDR_OFF_W-1:0] OFF_YMIN_LO = 7'd6;
    localparam logic [HDR_OFF_W-1:0] OFF_YMIN_HI = 7'd7;
    localparam logic [HDR_OFF_W-1:0] OFF_XMAX_LO = 7'd8;
    localparam logic [HDR_OFF_W-1:0] OFF_XMAX_HI = 7'd9;
    localparam logic [HDR_OFF_W-1:0] OFF_YMAX_LO = 7'd10;
    localparam logic [HDR_OFF_W-1:0] OFF_YMAX_HI = 7'd11;

    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_PALETTE = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_PIXELS  = 3'd1,
        PH_RUNVAL  = 3'd2,
        PH_SEEK    = 3'd3,
        PH_PALETTE = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
    } t_in_req;

    typedef struct packed {
        logic               kind;
        logic [7:0]         value;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row_number;
        logic [PAL_W-1:0]   palette_index;
        logic [COORD_W-1:0] image_width;
        logic [COORD_W-1:0] image_height;
        logic               last;
    } t_out_req;

    // Number of pixels spanned by signed bounds lo..hi, clamped to 0..65535.
    function automatic logic [COORD_W-1:0] extent(input logic [COORD_W-1:0] lo,
                                                  input logic [COORD_W-1:0] hi);
        logic signed [COORD_W+1:0] d;
        logic [COORD_W-1:0]        r;
        d = $signed({{2{hi[COORD_W-1]}}, hi}) - $signed({{2{lo[COORD_W-1]}}, lo})
            + $signed((COORD_W+2)'(1));
        if (d <= $signed((COORD_W+2)'(0))) begin
            r = '0;
        end else if (d[COORD_W+1:COORD_W] != 2'b00) begin
            r = '1;
        end else begin
            r = d[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pcx_rle_image_decoder.sv -----
// PCX run-length image decoder top level: header capture, row decoding and
// palette pass-through. Depends on pcx_pkg.
//
// Usage. File bytes arrive on the input channel (i_valid / o_ready /
// i_data), one request per byte; start_of_file on a byte restarts parsing
// with that byte as header offset 0. Results leave on the output channel
// (o_valid / i_ready / o_data): decoded pixels with their column and row,
// then palette bytes with their index. Every result carries the capped
// image width and height, and last marks the final result of its byte.
//
// Flow: a literal pixel or a palette byte appears in the output register
// in the cycle after its request is taken, and a new byte can be taken
// every cycle while no run is active and the output register is free. A
// run value byte loads the run counter, and its pixels follow one per cycle
// while the receiver does not stall, so a run holds o_ready low until it
// has given its last pixel.
// Header, run-count, marker-search and trailing bytes produce no result.
//
// Reset clears the parser to the header phase and empties the output
// register. When the receiver stalls, the held result stays in the output
// register and o_ready stays low until it is taken, whatever the next byte
// would produce, since o_ready follows i_ready combinationally.
`default_nettype none

module pcx_rle_image_decoder #(
    parameter int unsigned PALETTE_BYTES = pcx_pkg::PALETTE_BYTES
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  pcx_pkg::t_in_req  i_data,
    output logic              o_valid,
    input  wire               i_ready,
    output pcx_pkg::t_out_req o_data
);

    localparam int unsigned CW = pcx_pkg::COORD_W;
    localparam int unsigned PW = pcx_pkg::PAL_W;
    localparam int unsigned NW = pcx_pkg::COUNT_W;
    localparam int unsigned OW = pcx_pkg::HDR_OFF_W;

    // Parser state
    pcx_pkg::t_phase r_phase, n_phase;
    logic [OW-1:0]   r_hdr_off, n_hdr_off;
    logic [CW-1:0]   r_x_min, n_x_min, r_y_min, n_y_min;
    logic [CW-1:0]   r_x_max, n_x_max, r_y_max, n_y_max;
    logic [CW-1:0]   r_col, n_col, r_row, n_row;
    logic [NW-1:0]   r_pending, n_pending;
    logic [PW-1:0]   r_pal_pos, n_pal_pos;

    // Run generator: pixels still owed by the current run and their value
    logic [NW-1:0]   r_run_left, n_run_left;
    logic [7:0]      r_run_val, n_run_val;

    // Image size, recomputed every cycle from the captured window
    logic [CW-1:0]   r_width, r_height;

    // Output register
    logic              r_out_valid, n_out_valid;
    pcx_pkg::t_out_req r_out, n_out;

    // Handshake and decode terms
    logic            out_free, in_acc, run_active, run_go;
    logic            sof;
    logic [7:0]      byte_in;
    pcx_pkg::t_phase eff_phase;
    logic [OW-1:0]   eff_off;
    logic            is_run_byte, hdr_done, img_empty;
    logic            lit_go, pix_go, pal_go;
    logic [7:0]      pix_val;
    logic [CW:0]     col_inc, row_inc;
    logic            row_wrap, img_end, run_last;
    logic [PW:0]     pal_inc;
    logic            pal_end;

    assign byte_in    = i_data.data_byte;
    assign sof        = i_data.start_of_file;
    assign run_active = (r_run_left != '0);
    // The output register can take a result when empty or emptying now
    assign out_free   = !r_out_valid || i_ready;
    assign o_ready    = !run_active && out_free;
    assign in_acc     = i_valid && o_ready;
    assign run_go     = run_active && out_free;

    // A start-of-file byte is parsed as header offset 0 whatever came before
    assign eff_phase  = sof ? pcx_pkg::PH_HEADER : r_phase;
    assign eff_off    = sof ? '0 : r_hdr_off;

    assign is_run_byte = ((byte_in & pcx_pkg::RUN_MASK) == pcx_pkg::RUN_MASK);
    assign hdr_done    = ({1'b0, eff_off} + (OW+1)'(1)) >= (OW+1)'(pcx_pkg::HEADER_BYTES);
    assign img_empty   = (r_width == '0) || (r_height == '0);

    assign lit_go  = in_acc && (eff_phase == pcx_pkg::PH_PIXELS) && !is_run_byte;
    assign pal_go  = in_acc && (eff_phase == pcx_pkg::PH_PALETTE);
    assign pix_go  = run_go || lit_go;
    assign pix_val = run_go ? r_run_val : byte_in;

    // Pixel position step: advance the column, wrap to the next row at the
    // row end, and flag the end of the image after the last row.
    assign col_inc  = {1'b0, r_col} + (CW+1)'(1);
    assign row_inc  = {1'b0, r_row} + (CW+1)'(1);
    assign row_wrap = col_inc >= {1'b0, r_width};
    assign img_end  = row_wrap && (row_inc >= {1'b0, r_height});
    // A run stops at its count, at a row end, or at the end of the image
    assign run_last = (r_run_left == NW'(1)) || row_wrap;

    assign pal_inc = {1'b0, r_pal_pos} + (PW+1)'(1);
    assign pal_end = pal_inc[PW-1:0] >= PW'(PALETTE_BYTES) || pal_inc[PW];

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (pix_go && img_end) begin
            n_phase = pcx_pkg::PH_SEEK;
        end else if (in_acc) begin
            unique case (eff_phase)
                pcx_pkg::PH_HEADER: begin
                    if (hdr_done) begin
                        n_phase = img_empty ? pcx_pkg::PH_SEEK : pcx_pkg::PH_PIXELS;
                    end else begin
                        n_phase = pcx_pkg::PH_HEADER;
                    end
                end
                pcx_pkg::PH_PIXELS: begin
                    if (is_run_byte) begin
                        n_phase = pcx_pkg::PH_RUNVAL;
                    end
                end
                pcx_pkg::PH_RUNVAL: n_phase = pcx_pkg::PH_PIXELS;
                pcx_pkg::PH_SEEK: begin
                    if (byte_in == pcx_pkg::PALETTE_MARK) begin
                        n_phase = pcx_pkg::PH_PALETTE;
                    end
                end
                pcx_pkg::PH_PALETTE: begin
                    if (pal_end) begin
                        n_phase = pcx_pkg::PH_DONE;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // Datapath and result
    always_comb begin
        n_hdr_off   = r_hdr_off;
        n_x_min     = r_x_min;
        n_y_min     = r_y_min;
        n_x_max     = r_x_max;
        n_y_max     = r_y_max;
        n_col       = r_col;
        n_row       = r_row;
        n_pending   = r_pending;
        n_pal_pos   = r_pal_pos;
        n_run_left  = r_run_left;
        n_run_val   = r_run_val;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;

        if (in_acc && sof) begin
            n_x_min   = '0;
            n_y_min   = '0;
            n_x_max   = '0;
            n_y_max   = '0;
            n_col     = '0;
            n_row     = '0;
            n_pending = '0;
            n_pal_pos = '0;
        end

        if (in_acc) begin
            unique case (eff_phase)
                pcx_pkg::PH_HEADER: begin
                    unique case (eff_off)
                        pcx_pkg::OFF_XMIN_LO: n_x_min = {r_x_min[CW-1:8], byte_in};
                        pcx_pkg::OFF_XMIN_HI: n_x_min = {byte_in, r_x_min[7:0]};
                        pcx_pkg::OFF_YMIN_LO: n_y_min = {r_y_min[CW-1:8], byte_in};
                        pcx_pkg::OFF_YMIN_HI: n_y_min = {byte_in, r_y_min[7:0]};
                        pcx_pkg::OFF_XMAX_LO: n_x_max = {r_x_max[CW-1:8], byte_in};
                        pcx_pkg::OFF_XMAX_HI: n_x_max = {byte_in, r_x_max[7:0]};
                        pcx_pkg::OFF_YMAX_LO: n_y_max = {r_y_max[CW-1:8], byte_in};
                        pcx_pkg::OFF_YMAX_HI: n_y_max = {byte_in, r_y_max[7:0]};
                        default: ;
                    endcase
                    if (hdr_done) begin
                        n_hdr_off = '0;
                        n_col     = '0;
                        n_row     = '0;
                    end else begin
                        n_hdr_off = eff_off + OW'(1);
                    end
                end
                pcx_pkg::PH_PIXELS: begin
                    if (is_run_byte) begin
                        n_pending = NW'(byte_in & pcx_pkg::COUNT_MASK);
                    end
                end
                pcx_pkg::PH_RUNVAL: begin
                    // A zero count takes its value byte and gives nothing
                    n_run_left = r_pending;
                    n_run_val  = byte_in;
                    n_pending  = '0;
                end
                pcx_pkg::PH_SEEK: begin
                    if (byte_in == pcx_pkg::PALETTE_MARK) begin
                        n_pal_pos = '0;
                    end
                end
                pcx_pkg::PH_PALETTE: begin
                    n_pal_pos = pal_inc[PW-1:0];
                end
                default: ;
            endcase
        end

        if (pix_go) begin
            n_out_valid             = 1'b1;
            n_out.kind              = pcx_pkg::KIND_PIXEL;
            n_out.value             = pix_val;
            n_out.column            = r_col;
            n_out.row_number        = r_row;
            n_out.palette_index     = '0;
            n_out.image_width       = r_width;
            n_out.image_height      = r_height;
            n_out.last              = run_go ? run_last : 1'b1;
            if (row_wrap) begin
                n_col = '0;
                n_row = row_inc[CW-1:0];
            end else begin
                n_col = col_inc[CW-1:0];
            end
            if (run_go) begin
                n_run_left = run_last ? '0 : (r_run_left - NW'(1));
            end
        end else if (pal_go) begin
            n_out_valid             = 1'b1;
            n_out.kind              = pcx_pkg::KIND_PALETTE;
            n_out.value             = byte_in;
            n_out.column            = '0;
            n_out.row_number        = '0;
            n_out.palette_index     = r_pal_pos;
            n_out.image_width       = r_width;
            n_out.image_height      = r_height;
            n_out.last              = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pcx_pkg::PH_HEADER;
            r_hdr_off   <= '0;
            r_x_min     <= '0;
            r_y_min     <= '0;
            r_x_max     <= '0;
            r_y_max     <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_pending   <= '0;
            r_pal_pos   <= '0;
            r_run_left  <= '0;
            r_width     <= CW'(1);
            r_height    <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_off   <= n_hdr_off;
            r_x_min     <= n_x_min;
            r_y_min     <= n_y_min;
            r_x_max     <= n_x_max;
            r_y_max     <= n_y_max;
            r_col       <= n_col;
            r_row       <= n_row;
            r_pending   <= n_pending;
            r_pal_pos   <= n_pal_pos;
            r_run_left  <= n_run_left;
            // The window is written in the first dozen header bytes, long
            // before the size is first used, so the registered size lags harmlessly.
            r_width     <= pcx_pkg::extent(r_x_min, r_x_max);
            r_height    <= pcx_pkg::extent(r_y_min, r_y_max);
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_val <= n_run_val;
        r_out     <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ----- rtl/pcx_rle_chk.sv -----
// Port-level checker for the PCX decoder, bound to the top level.
// Depends on pcx_pkg and pcx_rle_image_decoder.
`default_nettype none

module pcx_rle_chk (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_valid,
    input wire               o_ready,
    input pcx_pkg::t_in_req  i_data,
    input wire               o_valid,
    input wire               i_ready,
    input pcx_pkg::t_out_req o_data
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_data))
        else $error("byte request changed while waiting");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result request changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result request valid after reset");

    a_pixel_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == pcx_pkg::KIND_PIXEL |->
            o_data.column < o_data.image_width && o_data.row_number < o_data.image_height
            && o_data.palette_index == '0)
        else $error("pixel outside the image window");

    a_palette_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.kind == pcx_pkg::KIND_PALETTE |->
            o_data.column == '0 && o_data.row_number == '0 && o_data.last)
        else $error("palette request carries pixel position");

endmodule

bind pcx_rle_image_decoder pcx_rle_chk u_pcx_rle_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

`default_nettype wire
